>>> src/swv_pkg.sv
// ----------------------------------------------------------------------------
// swv_pkg: shared types and constants for the sliding window variance block
// Holds the fixed field widths, the statistic selector and status codes, and
// the controller state type.
// ----------------------------------------------------------------------------
`default_nettype none

package swv_pkg;

	localparam int SUM_BITS       = 64;                // squared deviation sum
	localparam int STAT_BITS      = 48;                // statistic output field
	localparam int MEAN_OUT_BITS  = 32;                // mean_value output field
	localparam int COUNT_OUT_BITS = 16;                // sample_count output field
	localparam int SAMPLE_IN_BITS = 32;                // sample input field
	localparam int CI_NUM         = 2401;              // 1.96 squared is 2401/625
	localparam int CI_DEN         = 625;
	localparam int DIV_N_BITS     = SUM_BITS + 12;     // room for the sum times 2401
	localparam int SQRT_BITS      = DIV_N_BITS / 2;

	typedef enum logic [2:0] {
		SEL_SVAR = 3'd0,
		SEL_PVAR = 3'd1,
		SEL_SSTD = 3'd2,
		SEL_PSTD = 3'd3,
		SEL_SERR = 3'd4,
		SEL_CI   = 3'd5
	} sel_t;

	typedef enum logic [1:0] {
		STS_OK    = 2'd0,
		STS_EMPTY = 2'd1,
		STS_FULL  = 2'd2,
		STS_UNDER = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_MSTART,
		S_MDIV,
		S_MNEW,
		S_MULS,
		S_MUL,
		S_SUPD,
		S_STAT,
		S_PREP,
		S_SDIV,
		S_SQRT,
		S_FIN
	} state_t;

endpackage

`default_nettype wire

>>> src/sliding_window_variance.sv
// ----------------------------------------------------------------------------
// sliding_window_variance: running mean and variance with sample removal
// Welford update for adding and removing samples, followed by the selected
// statistic computed with a serial divider and, for the roots, a serial square root.
// ----------------------------------------------------------------------------
//
//  channel   dir  signals                        meaning
//  s_*       in   s_tvalid s_tready s_tdata      sample; s_tuser = op, present
//  m_*       out  m_tvalid m_tready m_tdata      mean, statistic, count
//                                 m_tuser        status
//  cfg_*     in   cfg_we cfg_wdata               statistic selector
//
// An update runs the serial divider for the mean step and then the serial
// multiplier for the deviation product. The statistic then runs the same
// divider for a variance, and the square root unit after it for a root.
// Reset clears the window and the selector; no clearing pass is needed.
// A new request is taken as soon as the result sits in the output register,
// and a stalled output holds the controller only when a second result is ready.
// ----------------------------------------------------------------------------
`default_nettype none

module sliding_window_variance import swv_pkg::*; #(
	parameter int SAMPLE_BITS = 32,
	parameter int FRAC_BITS   = 16,
	parameter int COUNT_BITS  = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,   // sample
	input  wire logic [1:0]  s_tuser,   // op, sample_present
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [95:0]      m_tdata,   // mean_value, statistic, sample_count
	output logic [1:0]       m_tuser,   // status
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_wdata  // stat_select
);

	localparam int G         = (SAMPLE_BITS > 46) ? 62 - SAMPLE_BITS : 16;
	localparam int MEAN_BITS = SAMPLE_BITS + G;
	localparam int MW        = MEAN_BITS + 1;
	localparam int AW        = ((MW > COUNT_BITS) ? MW : COUNT_BITS) + 1;
	localparam int NW        = ((MEAN_BITS > AW) ? MEAN_BITS : AW) + 2;
	localparam int DD_A      = COUNT_BITS + FRAC_BITS;
	localparam int DD_B      = 2 * COUNT_BITS + 10;
	localparam int DD_W      = (DD_A > DD_B) ? DD_A : DD_B;
	localparam int PW        = 2 * MW + 1;
	localparam int TW        = PW - 2 * G;
	localparam int EW        = (TW > SUM_BITS) ? TW : SUM_BITS + 1;
	localparam int OB        = (SAMPLE_BITS > MEAN_OUT_BITS) ? MEAN_OUT_BITS : SAMPLE_BITS;
	localparam logic [PW-1:0]        RHALF = PW'(1) << (2 * G - 1);
	localparam logic [MEAN_BITS:0]   MHALF = (MEAN_BITS+1)'(1) << (G - 1);

	state_t state_q, state_d;
	sel_t   sel_q;

	logic [COUNT_BITS-1:0]       count_q;
	logic signed [MEAN_BITS-1:0] mean_q;
	logic [SUM_BITS-1:0]         ssum_q;

	logic                        op_q;
	logic signed [MEAN_BITS-1:0] xs_q;
	logic signed [MW-1:0]        delta_q;
	status_t                     status_q;
	logic                        neg_q;
	logic [SUM_BITS-1:0]         term_q;
	logic [2*COUNT_BITS-1:0]     nn1_q;
	logic [DD_W-1:0]             dsr_q;
	logic [STAT_BITS-1:0]        stat_q;

	logic                        out_valid_q;
	logic [MEAN_OUT_BITS-1:0]    mean_out_q;
	logic [STAT_BITS-1:0]        stat_out_q;
	logic [COUNT_OUT_BITS-1:0]   cnt_out_q;
	status_t                     status_out_q;

	logic div_start, mul_start, sqrt_start, out_load;
	logic div_done, mul_done, sqrt_done;
	logic [DIV_N_BITS-1:0] div_quo;
	logic [DD_W-1:0]       div_rem;
	logic [2*MW-1:0]       mul_prod;
	logic [SQRT_BITS-1:0]  sqrt_root;

	logic                        acc;
	logic                        op_in, present_in;
	logic [SAMPLE_BITS-1:0]      raw_c;
	logic signed [MEAN_BITS-1:0] xs_c;
	logic signed [MW-1:0]        delta_c;
	logic                        full_c;
	logic                        go_mean;

	assign op_in      = s_tuser[0];
	assign present_in = s_tuser[1];
	assign raw_c      = SAMPLE_BITS'(s_tdata[SAMPLE_IN_BITS-1:0]);
	assign xs_c       = {raw_c, {G{1'b0}}};
	assign delta_c    = MW'(xs_c) - MW'(mean_q);
	assign full_c     = &count_q;
	assign s_tready   = (state_q == S_IDLE);
	assign acc        = s_tvalid && s_tready;
	assign go_mean    = present_in && (op_in ? (count_q > COUNT_BITS'(1))
	                                         : (!full_c && count_q != '0));

	// Mean step: round |delta| / n half away from zero.
	logic [MW-1:0]         dmag_c;
	logic [AW-1:0]         mdiv_c;
	logic [AW-1:0]         mq_c;
	logic signed [NW-1:0]  qs_c, newm_w;
	logic                  flip_c, movf_c;
	logic signed [MEAN_BITS-1:0] newm_c;

	assign dmag_c = delta_q[MW-1] ? MW'(-delta_q) : delta_q;
	assign mdiv_c = AW'(dmag_c) + AW'(count_q >> 1);
	assign mq_c   = div_quo[AW-1:0];
	assign qs_c   = signed'(NW'(mq_c));
	assign flip_c = delta_q[MW-1] ^ op_q;
	assign newm_w = NW'(mean_q) + (flip_c ? -qs_c : qs_c);
	assign movf_c = !(&newm_w[NW-1:MEAN_BITS-1] || ~|newm_w[NW-1:MEAN_BITS-1]);
	assign newm_c = movf_c ? (newm_w[NW-1] ? {1'b1, {(MEAN_BITS-1){1'b0}}}
	                                        : {1'b0, {(MEAN_BITS-1){1'b1}}})
	                       : newm_w[MEAN_BITS-1:0];

	// Deviation product operands, taken after the mean has moved.
	logic signed [MW-1:0] bdiff_c;
	logic [MW-1:0]        bmag_c;
	logic [PW-1:0]        prnd_c;
	logic [EW-1:0]        psh_c;
	logic [SUM_BITS-1:0]  term_c;

	assign bdiff_c = MW'(xs_q) - MW'(mean_q);
	assign bmag_c  = bdiff_c[MW-1] ? MW'(-bdiff_c) : bdiff_c;
	assign prnd_c  = PW'(mul_prod) + RHALF;
	assign psh_c   = EW'(prnd_c >> (2 * G));
	assign term_c  = (|psh_c[EW-1:SUM_BITS]) ? '1 : psh_c[SUM_BITS-1:0];

	logic [SUM_BITS:0] sadd_c;
	logic              sub_c;
	assign sadd_c = (SUM_BITS+1)'(ssum_q) + (SUM_BITS+1)'(term_q);
	assign sub_c  = neg_q ^ op_q;

	// Statistic operands.
	logic [COUNT_BITS-1:0] nm1_c;
	logic                  by_sample_c, stat_zero_c, is_var_c;
	logic [DD_W-1:0]       sdsr_c;
	logic [DIV_N_BITS-1:0] sdvd_c;

	assign nm1_c       = count_q - COUNT_BITS'(1);
	assign by_sample_c = (sel_q == SEL_SVAR) || (sel_q == SEL_SSTD) ||
	                     (sel_q == SEL_SERR) || (sel_q == SEL_CI);
	assign is_var_c    = (sel_q == SEL_SVAR) || (sel_q == SEL_PVAR);

	always_comb begin
		stat_zero_c = (count_q == '0) || (by_sample_c && count_q == COUNT_BITS'(1));
		sdvd_c      = DIV_N_BITS'(ssum_q);
		sdsr_c      = DD_W'(count_q);
		case (sel_q)
			SEL_SVAR: sdsr_c = DD_W'(nm1_c) << FRAC_BITS;
			SEL_PVAR: sdsr_c = DD_W'(count_q) << FRAC_BITS;
			SEL_SSTD: sdsr_c = DD_W'(nm1_c);
			SEL_PSTD: sdsr_c = DD_W'(count_q);
			SEL_SERR: sdsr_c = DD_W'(nn1_q);
			SEL_CI: begin
				sdsr_c = DD_W'(nn1_q) * DD_W'(CI_DEN);
				sdvd_c = DIV_N_BITS'(ssum_q) * DIV_N_BITS'(CI_NUM);
			end
			default: stat_zero_c = 1'b1;
		endcase
	end

	logic [DIV_N_BITS:0]  vq_c;
	logic [STAT_BITS-1:0] vsat_c;
	assign vq_c   = (DIV_N_BITS+1)'(div_quo) +
	                (DIV_N_BITS+1)'({div_rem, 1'b0} >= {1'b0, dsr_q});
	assign vsat_c = (|vq_c[DIV_N_BITS:STAT_BITS]) ? '1 : vq_c[STAT_BITS-1:0];

	// Output mean: round to the sample scale, then clamp to the output range.
	logic signed [MEAN_BITS:0]     mr_c;
	logic signed [SAMPLE_BITS:0]   ms_c;
	logic signed [OB-1:0]          mcl_c;
	logic [MEAN_OUT_BITS-1:0]      mv_c;
	logic [COUNT_OUT_BITS-1:0]     cnt_out_c;
	status_t                       sts_c;

	assign mr_c  = (MEAN_BITS+1)'(mean_q) + signed'(MHALF);
	assign ms_c  = mr_c[MEAN_BITS:G];
	assign mcl_c = (&ms_c[SAMPLE_BITS:OB-1] || ~|ms_c[SAMPLE_BITS:OB-1]) ? ms_c[OB-1:0]
	             : (ms_c[SAMPLE_BITS] ? {1'b1, {(OB-1){1'b0}}} : {1'b0, {(OB-1){1'b1}}});
	assign mv_c  = (count_q == '0) ? '0 : MEAN_OUT_BITS'(mcl_c);
	assign cnt_out_c = ((COUNT_BITS > COUNT_OUT_BITS) && ((count_q >> COUNT_OUT_BITS) != '0))
	                 ? '1 : COUNT_OUT_BITS'(count_q);
	assign sts_c = (status_q == STS_OK && count_q == '0) ? STS_EMPTY : status_q;

	logic [DIV_N_BITS-1:0] div_dvd;
	logic [DD_W-1:0]       div_dsr;
	assign div_dvd = (state_q == S_MSTART) ? DIV_N_BITS'(mdiv_c) : sdvd_c;
	assign div_dsr = (state_q == S_MSTART) ? DD_W'(count_q) : sdsr_c;

	swv_div #(.N_W(DIV_N_BITS), .D_W(DD_W)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (div_dsr),
		.done     (div_done),
		.quotient (div_quo),
		.remainder(div_rem)
	);

	swv_mul #(.W(MW)) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (dmag_c),
		.b      (bmag_c),
		.done   (mul_done),
		.product(mul_prod)
	);

	swv_sqrt #(.R_W(SQRT_BITS)) u_sqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (sqrt_start),
		.radicand(div_quo),
		.done    (sqrt_done),
		.root    (sqrt_root)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		div_start  = 1'b0;
		mul_start  = 1'b0;
		sqrt_start = 1'b0;
		out_load   = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					state_d = go_mean ? S_MSTART : S_STAT;
				end
			end
			S_MSTART: begin
				div_start = 1'b1;
				state_d   = S_MDIV;
			end
			S_MDIV: begin
				if (div_done) begin
					state_d = S_MNEW;
				end
			end
			S_MNEW: state_d = S_MULS;
			S_MULS: begin
				mul_start = 1'b1;
				state_d   = S_MUL;
			end
			S_MUL: begin
				if (mul_done) begin
					state_d = S_SUPD;
				end
			end
			S_SUPD: state_d = S_STAT;
			S_STAT: state_d = stat_zero_c ? S_FIN : S_PREP;
			S_PREP: begin
				div_start = 1'b1;
				state_d   = S_SDIV;
			end
			S_SDIV: begin
				if (div_done) begin
					if (is_var_c) begin
						state_d = S_FIN;
					end else begin
						sqrt_start = 1'b1;
						state_d    = S_SQRT;
					end
				end
			end
			S_SQRT: begin
				if (sqrt_done) begin
					state_d = S_FIN;
				end
			end
			S_FIN: begin
				if (!out_valid_q || m_tready) begin
					out_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Window state and selector.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			mean_q      <= '0;
			ssum_q      <= '0;
			sel_q       <= SEL_SVAR;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				sel_q <= sel_t'(cfg_wdata);
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			if (acc && present_in) begin
				if (!op_in) begin
					if (count_q == '0) begin
						count_q <= COUNT_BITS'(1);
						mean_q  <= xs_c;
						ssum_q  <= '0;
					end else if (!full_c) begin
						count_q <= count_q + COUNT_BITS'(1);
					end
				end else if (count_q == COUNT_BITS'(1)) begin
					count_q <= '0;
					mean_q  <= '0;
					ssum_q  <= '0;
				end else if (count_q != '0) begin
					count_q <= nm1_c;
				end
			end
			if (state_q == S_MNEW) begin
				mean_q <= newm_c;
			end
			if (state_q == S_SUPD) begin
				if (sub_c) begin
					ssum_q <= (ssum_q > term_q) ? ssum_q - term_q : '0;
				end else begin
					ssum_q <= sadd_c[SUM_BITS] ? '1 : sadd_c[SUM_BITS-1:0];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			op_q    <= op_in;
			xs_q    <= xs_c;
			delta_q <= delta_c;
			if (!present_in) begin
				status_q <= STS_OK;
			end else if (!op_in) begin
				status_q <= full_c ? STS_FULL : STS_OK;
			end else begin
				status_q <= (count_q == '0) ? STS_UNDER : STS_OK;
			end
		end
		if (state_q == S_MULS) begin
			neg_q <= (delta_q[MW-1] != bdiff_c[MW-1]) && (delta_q != '0) && (bdiff_c != '0);
		end
		if (state_q == S_MUL && mul_done) begin
			term_q <= term_c;
		end
		if (state_q == S_STAT) begin
			nn1_q  <= (2*COUNT_BITS)'(count_q) * (2*COUNT_BITS)'(nm1_c);
			stat_q <= '0;
		end
		if (state_q == S_PREP) begin
			dsr_q <= sdsr_c;
		end
		if (state_q == S_SDIV && div_done && is_var_c) begin
			stat_q <= vsat_c;
		end
		if (state_q == S_SQRT && sqrt_done) begin
			stat_q <= STAT_BITS'(sqrt_root);
		end
		if (out_load) begin
			mean_out_q   <= mv_c;
			stat_out_q   <= stat_q;
			cnt_out_q    <= cnt_out_c;
			status_out_q <= sts_c;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {cnt_out_q, stat_out_q, mean_out_q};
	assign m_tuser  = status_out_q;

`ifndef ASSERT_OFF
	a_empty_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && count_q == '0) |-> (mean_q == '0 && ssum_q == '0))
		else $error("empty window holds a nonzero mean or sum");

	a_div_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == S_MDIV || state_q == S_SDIV))
		else $error("divider finished outside a divide state");

	a_sqrt_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		sqrt_done |-> (state_q == S_SQRT))
		else $error("square root finished outside its state");

	a_ok_needs_samples: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> (status_out_q != STS_OK || cnt_out_q != '0))
		else $error("status ok reported with an empty window");
`endif

endmodule

`default_nettype wire

>>> src/swv_div.sv
// ----------------------------------------------------------------------------
// swv_div: bit-serial restoring divider
// Produces one quotient bit per cycle; done pulses once the quotient and the
// remainder are final.
// ----------------------------------------------------------------------------
`default_nettype none

module swv_div import swv_pkg::*; #(
	parameter int N_W = 76,
	parameter int D_W = 58
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	input  wire logic [N_W-1:0] dividend,
	input  wire logic [D_W-1:0] divisor,
	output logic                done,
	output logic [N_W-1:0]      quotient,
	output logic [D_W-1:0]      remainder
);

	localparam int CW = $clog2(N_W + 1);

	logic [CW-1:0]  cnt_q;
	logic           done_q;
	logic [N_W-1:0] quo_q;
	logic [D_W-1:0] rem_q;
	logic [D_W-1:0] dsr_q;
	logic [D_W:0]   trial;
	logic           ge;

	assign trial = {rem_q, quo_q[N_W-1]};
	assign ge    = trial >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (cnt_q == CW'(1));
			if (start) begin
				cnt_q <= CW'(N_W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (cnt_q != '0) begin
			quo_q <= {quo_q[N_W-2:0], ge};
			rem_q <= ge ? D_W'(trial - {1'b0, dsr_q}) : D_W'(trial);
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

`default_nettype wire

>>> src/swv_mul.sv
// ----------------------------------------------------------------------------
// swv_mul: bit-serial shift-add multiplier
// Consumes one multiplier bit per cycle from the low end of the product
// register.
// ----------------------------------------------------------------------------
`default_nettype none

module swv_mul import swv_pkg::*; #(
	parameter int W = 49
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         start,
	input  wire logic [W-1:0] a,
	input  wire logic [W-1:0] b,
	output logic              done,
	output logic [2*W-1:0]    product
);

	localparam int CW = $clog2(W + 1);

	logic [CW-1:0]  cnt_q;
	logic           done_q;
	logic [W-1:0]   a_q;
	logic [2*W-1:0] prod_q;
	logic [W:0]     psum;

	assign psum = (W+1)'(prod_q[2*W-1:W]) + (W+1)'(prod_q[0] ? a_q : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (cnt_q == CW'(1));
			if (start) begin
				cnt_q <= CW'(W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q    <= a;
			prod_q <= {{W{1'b0}}, b};
		end else if (cnt_q != '0) begin
			prod_q <= {psum, prod_q[W-1:1]};
		end
	end

	assign done    = done_q;
	assign product = prod_q;

endmodule

`default_nettype wire

>>> src/swv_sqrt.sv
// ----------------------------------------------------------------------------
// swv_sqrt: digit-serial integer square root
// Takes two radicand bits and yields one root bit per cycle (floor root).
// ----------------------------------------------------------------------------
`default_nettype none

module swv_sqrt import swv_pkg::*; #(
	parameter int R_W = 38
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [2*R_W-1:0] radicand,
	output logic                  done,
	output logic [R_W-1:0]        root
);

	localparam int CW = $clog2(R_W + 1);

	logic [CW-1:0]    cnt_q;
	logic             done_q;
	logic [2*R_W-1:0] rad_q;
	logic [R_W:0]     rem_q;
	logic [R_W-1:0]   root_q;
	logic [R_W+2:0]   cur;
	logic [R_W+2:0]   trial;
	logic             ge;

	assign cur   = {rem_q, rad_q[2*R_W-1:2*R_W-2]};
	assign trial = {1'b0, root_q, 2'b01};
	assign ge    = cur >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (cnt_q == CW'(1));
			if (start) begin
				cnt_q <= CW'(R_W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	// The partial remainder never exceeds twice the partial root.
	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (cnt_q != '0) begin
			rad_q  <= {rad_q[2*R_W-3:0], 2'b00};
			rem_q  <= ge ? (R_W+1)'(cur - trial) : (R_W+1)'(cur);
			root_q <= {root_q[R_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

`default_nettype wire

>>> tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the sliding window variance block
// Requests that add, remove or skip samples are offered with random gaps and
// checked against a bit-exact Welford predictor. The receiver stalls at
// random, and once for a long stretch. Every selector setting is exercised.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench import swv_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [63:0] STAT_SAT  = (64'd1 << 48) - 1;
	localparam longint      MEAN_HIGH = (64'sd1 <<< 47) - 1;
	localparam longint      MEAN_LOW  = -MEAN_HIGH - 1;
	localparam int          SETTLE    = 300;

	typedef struct packed {
		logic        remove;
		logic [31:0] sample;
		logic        present;
	} request_t;

	typedef struct packed {
		logic [31:0] mean_value;
		logic [47:0] statistic;
		logic [15:0] sample_count;
		status_t     status;
	} window_result_t;

	logic        clk, arst_n;
	logic        s_tvalid, s_tready, m_tvalid, m_tready, cfg_we;
	logic [31:0] s_tdata;
	logic [1:0]  s_tuser, m_tuser;
	logic [95:0] m_tdata;
	logic [2:0]  cfg_wdata;

	sliding_window_variance u_top (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	// Predictor state.
	logic [63:0]    win_count;
	longint         win_mean;
	logic [63:0]    dev_sum;
	logic [2:0]     stat_sel;

	request_t       pending_requests[$];
	window_result_t expected_results[$];
	logic [31:0]    held_samples[$];
	request_t       cur_request;
	bit             in_flight, sent, no_idle;
	int             send_wait, recv_wait, hold_off;
	int             failures;

	function automatic logic [63:0] isqrt(logic [127:0] v);
		logic [63:0]  res, c;
		logic [127:0] sq;
		res = 0;
		for (int b = 63; b >= 0; b--) begin
			c = res | (64'd1 << b);
			sq = 128'(c) * 128'(c);
			if (sq <= v) res = c;
		end
		return res;
	endfunction

	function automatic logic [47:0] selected_statistic();
		logic [63:0]  n, d, q, r;
		logic [127:0] w;
		bit           by_sample;
		n = win_count;
		by_sample = stat_sel inside {SEL_SVAR, SEL_SSTD, SEL_SERR, SEL_CI};
		if (n == 0 || (by_sample && n == 1)) return '0;
		case (stat_sel)
			SEL_SVAR, SEL_PVAR: begin
				d = (stat_sel == SEL_SVAR ? n - 1 : n) << 16;
				q = dev_sum / d;
				r = dev_sum % d;
				if (r >= d - r) q++;
			end
			SEL_SSTD: q = isqrt(128'(dev_sum / (n - 1)));
			SEL_PSTD: q = isqrt(128'(dev_sum / n));
			SEL_SERR: q = isqrt(128'(dev_sum / (n * (n - 1))));
			SEL_CI: begin
				w = 128'(dev_sum) * CI_NUM;
				w = w / 128'(n * (n - 1));
				w = w / CI_DEN;
				q = isqrt(w);
			end
			default: q = 0;
		endcase
		return q > STAT_SAT ? STAT_SAT[47:0] : q[47:0];
	endfunction

	// Deviation product rounded half up to the sum's scale, magnitude saturated.
	function automatic logic [63:0] deviation_term(longint a, longint b, output bit neg);
		logic [63:0]  ua, ub;
		logic [127:0] p;
		ua = a < 0 ? -a : a;
		ub = b < 0 ? -b : b;
		p = (128'(ua) * 128'(ub) + (128'd1 << 31)) >> 32;
		neg = ((a < 0) != (b < 0)) && ua != 0 && ub != 0;
		return p[127:64] != 0 ? '1 : p[63:0];
	endfunction

	function automatic longint mean_step(longint v, logic [63:0] n);
		logic [63:0] u, q;
		u = v < 0 ? -v : v;
		q = (u + n / 2) / n;
		return v < 0 ? -longint'(q) : longint'(q);
	endfunction

	function automatic logic [63:0] sum_up(logic [63:0] s, logic [63:0] t);
		logic [64:0] x;
		x = 65'(s) + 65'(t);
		return x[64] ? '1 : x[63:0];
	endfunction

	function automatic logic [63:0] sum_down(logic [63:0] s, logic [63:0] t);
		return s > t ? s - t : '0;
	endfunction

	function automatic window_result_t update_window(request_t rq);
		window_result_t res;
		longint         xs, delta, newm, mv;
		logic [63:0]    term;
		bit             neg;
		res.status = STS_OK;
		xs = longint'($signed(rq.sample)) * 65536;
		if (rq.present) begin
			if (!rq.remove) begin
				if (win_count >= 65535) begin
					res.status = STS_FULL;
				end else if (win_count == 0) begin
					win_count = 1;
					win_mean = xs;
					dev_sum = 0;
				end else begin
					win_count++;
					delta = xs - win_mean;
					newm = win_mean + mean_step(delta, win_count);
					term = deviation_term(delta, xs - newm, neg);
					win_mean = newm;
					dev_sum = neg ? sum_down(dev_sum, term) : sum_up(dev_sum, term);
				end
			end else begin
				if (win_count == 0) begin
					res.status = STS_UNDER;
				end else if (win_count == 1) begin
					win_count = 0;
					win_mean = 0;
					dev_sum = 0;
				end else begin
					win_count--;
					delta = xs - win_mean;
					newm = win_mean - mean_step(delta, win_count);
					if (newm > MEAN_HIGH) newm = MEAN_HIGH;
					if (newm < MEAN_LOW) newm = MEAN_LOW;
					term = deviation_term(delta, xs - newm, neg);
					win_mean = newm;
					dev_sum = neg ? sum_up(dev_sum, term) : sum_down(dev_sum, term);
				end
			end
		end
		if (res.status == STS_OK && win_count == 0) res.status = STS_EMPTY;
		mv = 0;
		if (win_count != 0) begin
			mv = (win_mean + 32768) >>> 16;
			if (mv > 64'sh7FFF_FFFF) mv = 64'sh7FFF_FFFF;
			if (mv < -64'sh8000_0000) mv = -64'sh8000_0000;
		end
		res.mean_value = mv[31:0];
		res.statistic = selected_statistic();
		res.sample_count = win_count[15:0];
		return res;
	endfunction

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// Sender: one request in flight at a time, random gap before each unless no_idle is set.
	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready) begin
			expected_results.push_back(update_window(cur_request));
			sent = 1;
		end
	end

	always @(negedge clk) begin
		if (sent) begin
			in_flight = 0;
			sent = 0;
			send_wait = no_idle ? 0 : $urandom_range(0, 12);
		end
		if (arst_n && !in_flight && pending_requests.size() > 0) begin
			if (send_wait > 0) begin
				send_wait--;
			end else begin
				cur_request = pending_requests.pop_front();
				s_tdata <= cur_request.sample;
				s_tuser <= {cur_request.present, cur_request.remove};
				in_flight = 1;
			end
		end
		s_tvalid <= in_flight;
	end

	// Receiver: compares each result with the oldest expectation.
	always @(posedge clk) begin
		window_result_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got = {m_tdata[31:0], m_tdata[79:32], m_tdata[95:80], status_t'(m_tuser)};
			if (expected_results.size() == 0) begin
				$error("unexpected result %h", got);
				failures++;
			end else begin
				want = expected_results.pop_front();
				if (got.mean_value !== want.mean_value) begin
					$error("mean_value expected %h got %h", want.mean_value, got.mean_value);
					failures++;
				end
				if (got.statistic !== want.statistic) begin
					$error("statistic expected %h got %h", want.statistic, got.statistic);
					failures++;
				end
				if (got.sample_count !== want.sample_count) begin
					$error("sample_count expected %0d got %0d",
						want.sample_count, got.sample_count);
					failures++;
				end
				if (got.status !== want.status) begin
					$error("status expected %0d got %0d", want.status, got.status);
					failures++;
				end
			end
			recv_wait = no_idle ? 0 : $urandom_range(0, 12);
		end
	end

	always @(negedge clk) begin
		if (hold_off > 0) begin
			hold_off--;
			m_tready <= 0;
		end else if (recv_wait > 0) begin
			recv_wait--;
			m_tready <= 0;
		end else begin
			m_tready <= 1;
		end
	end

	task automatic queue_request(bit rm, logic [31:0] smp, bit present);
		request_t rq;
		rq.remove = rm;
		rq.sample = smp;
		rq.present = present;
		pending_requests.push_back(rq);
	endtask

	task automatic wait_drained();
		while (pending_requests.size() > 0 || in_flight || expected_results.size() > 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic write_selector(logic [2:0] sel);
		wait_drained();
		@(negedge clk);
		cfg_we <= 1;
		cfg_wdata <= sel;
		stat_sel = sel;
		@(negedge clk);
		cfg_we <= 0;
	endtask

	function automatic logic [31:0] random_sample();
		case ($urandom_range(0, 3))
			0: return $urandom;
			1: return 32'($signed($urandom_range(0, 2000)) - 1000) <<< 16;
			default: return 32'($signed($urandom_range(0, 13_000_000)) - 6_500_000);
		endcase
	endfunction

	initial begin
		logic [2:0]  phase_sel[8];
		logic [31:0] v;
		int          idx;
		phase_sel = '{SEL_SVAR, SEL_PVAR, SEL_SSTD, SEL_PSTD, SEL_SERR, SEL_CI,
			3'd6, 3'd7};
		failures = 0;
		win_count = 0; win_mean = 0; dev_sum = 0; stat_sel = SEL_SVAR;
		in_flight = 0; sent = 0; no_idle = 0;
		send_wait = 0; recv_wait = 0; hold_off = 0;
		s_tvalid = 0; s_tdata = 0; s_tuser = 0; m_tready = 0;
		cfg_we = 0; cfg_wdata = 0;
		arst_n = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// Directed: empty window, extremes, single sample, clearing, strays.
		queue_request(1, 32'h0001_0000, 1);
		queue_request(0, 32'h1234_5678, 0);
		queue_request(0, 32'h7FFF_FFFF, 1);
		queue_request(0, 32'h8000_0000, 1);
		queue_request(1, 32'h1234_5678, 0);
		queue_request(1, 32'h8000_0000, 1);
		queue_request(1, 32'h7FFF_FFFF, 1);
		queue_request(0, 32'hFFFF_FFFF, 1);
		queue_request(0, 32'h0000_0000, 1);
		queue_request(0, 32'h0003_8000, 1);
		queue_request(1, 32'h7FFF_FFFF, 1);
		queue_request(1, 32'h8000_0000, 1);
		queue_request(1, 32'h0000_0000, 1);
		queue_request(1, 32'h0000_0000, 1);
		queue_request(1, 32'h0000_0000, 1);
		for (int s = 0; s < 8; s++) begin
			write_selector(phase_sel[s]);
			queue_request(0, 32'h0002_0000, 1);
			queue_request(0, 32'hFFFE_0000, 1);
			queue_request(0, 32'h0005_4000, 1);
			queue_request(1, 32'h0002_0000, 1);
			queue_request(1, 32'hFFFE_0000, 1);
			queue_request(1, 32'h0005_4000, 1);
		end

		// Random: mostly balanced add/remove traffic over a small window.
		for (int ph = 0; ph < 16; ph++) begin
			write_selector(ph == 15 ? SEL_CI : phase_sel[ph % 8]);
			no_idle = (ph % 4 == 3);
			if (ph == 2) hold_off = 600;
			for (int i = 0; i < 88; i++) begin
				case ($urandom_range(0, 19))
					0, 1: queue_request($urandom_range(0, 1), $urandom, 0);
					2: queue_request(1, random_sample(), 1);
					3: begin
						while (held_samples.size() > 0)
							queue_request(1, held_samples.pop_back(), 1);
					end
					default: begin
						if (held_samples.size() < 40 && ($urandom_range(0, 2) != 0
							|| held_samples.size() == 0)) begin
							v = random_sample();
							held_samples.push_back(v);
							queue_request(0, v, 1);
						end else begin
							idx = $urandom_range(0, held_samples.size() - 1);
							queue_request(1, held_samples[idx], 1);
							held_samples.delete(idx);
						end
					end
				endcase
			end
		end
		wait_drained();
		if (failures == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

	initial begin
		#20ms;
		$display("FAILURE");
		$finish;
	end

endmodule

`default_nettype wire
